// ----- hw/rtl/tcw_pkg.sv -----
// shared constants and command codes for the text console writer
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CMD_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int COLIN_W = 7;
    localparam int ROWIN_W = 5;
    localparam int CELL_W  = 16;

    localparam logic [ATTR_W-1:0] DEF_ATTR = 8'h0F;

    localparam logic [CMD_W-1:0] CMD_PUT     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_NEWLINE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SETCUR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

endpackage

// ----- hw/rtl/tcw_screen_mem.sv -----
// screen cell store, one write port and one registered read port
module tcw_screen_mem #(
    parameter int CELLS  = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
    parameter int ADDR_W = $clog2(CELLS)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [tcw_pkg::CELL_W-1:0] wdata,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [tcw_pkg::CELL_W-1:0] rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/tcw_ctrl.sv -----
// command sequencer with cursor, sweep counter and store addressing
module tcw_ctrl #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS,
    parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tcw_pkg::CMD_W-1:0]   cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
    input  logic [tcw_pkg::COLIN_W-1:0] col,
    input  logic [tcw_pkg::ROWIN_W-1:0] row,
    input  logic [tcw_pkg::ATTR_W-1:0]  attr,
    input  logic [tcw_pkg::CELL_W-1:0]  rdata,
    output logic                        busy,
    output logic                        done,
    output logic [tcw_pkg::CELL_W-1:0]  cell_data,
    output logic [tcw_pkg::COLIN_W-1:0] cursor_col,
    output logic [tcw_pkg::ROWIN_W-1:0] cursor_row,
    output logic                        mem_we,
    output logic [ADDR_W-1:0]           mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0]  mem_wdata,
    output logic [ADDR_W-1:0]           mem_raddr
);
    import tcw_pkg::*;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COPIES = (ROWS - 1) * COLUMNS;
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(COPIES - 1);

    typedef enum logic [4:0] {
        S_INIT   = 5'b00001,
        S_IDLE   = 5'b00010,
        S_CLEAR  = 5'b00100,
        S_SCROLL = 5'b01000,
        S_DRAIN  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0] cp_addr_reg, cp_addr_next;
    logic              cp_valid_reg, cp_valid_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic              done_reg, done_next;
    logic              rd_ok_reg, rd_ok_next;

    logic [31:0]       cur_lin;
    logic [31:0]       req_lin;
    logic [31:0]       src_lin;
    logic [31:0]       col_ext;
    logic [31:0]       row_ext;
    logic              in_range;
    logic [ADDR_W-1:0] cnt_inc;

    assign cur_lin  = 32'(cur_row_reg) * COLUMNS + 32'(cur_col_reg);
    assign req_lin  = 32'(row) * COLUMNS + 32'(col);
    assign src_lin  = 32'(cnt_reg) + COLUMNS;
    assign in_range = (32'(col) < COLUMNS) && (32'(row) < ROWS);
    assign cnt_inc  = cnt_reg + ADDR_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cp_addr_next  = cp_addr_reg;
        cp_valid_next = 1'b0;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        done_next     = 1'b0;
        rd_ok_next    = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = cnt_reg;
        mem_wdata     = '0;
        mem_raddr     = '0;

        unique case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_PUT:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_lin[ADDR_W-1:0];
                            mem_wdata = {attr, char_code};
                            if (32'(cur_col_reg) == COLUMNS - 1)
                            begin
                                cur_col_next = '0;
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + COL_W'(1);
                            end
                            done_next = 1'b1;
                        end
                        CMD_NEWLINE:
                        begin
                            cur_col_next = '0;
                            if (32'(cur_row_reg) + 32'd1 < ROWS)
                            begin
                                cur_row_next = cur_row_reg + ROW_W'(1);
                                done_next    = 1'b1;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                state_next = S_SCROLL;
                            end
                        end
                        CMD_SETCUR:
                        begin
                            cur_col_next = (32'(col) < COLUMNS) ? COL_W'(col)
                                                                : COL_W'(COLUMNS - 1);
                            cur_row_next = (32'(row) < ROWS) ? ROW_W'(row)
                                                             : ROW_W'(ROWS - 1);
                            done_next    = 1'b1;
                        end
                        CMD_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = S_CLEAR;
                        end
                        CMD_READ:
                        begin
                            mem_raddr  = in_range ? req_lin[ADDR_W-1:0] : '0;
                            rd_ok_next = in_range;
                            done_next  = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            S_SCROLL:
            begin
                // read one row below, write the beat read last cycle
                mem_raddr     = src_lin[ADDR_W-1:0];
                cp_valid_next = 1'b1;
                cp_addr_next  = cnt_reg;
                mem_we        = cp_valid_reg;
                mem_waddr     = cp_addr_reg;
                mem_wdata     = rdata;
                if (cnt_reg == LAST_COPY)
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            S_DRAIN:
            begin
                mem_we     = cp_valid_reg;
                mem_waddr  = cp_addr_reg;
                mem_wdata  = rdata;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            cnt_reg      <= '0;
            cp_valid_reg <= 1'b0;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            done_reg     <= 1'b0;
            rd_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            cp_valid_reg <= cp_valid_next;
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            done_reg     <= done_next;
            rd_ok_reg    <= rd_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_addr_reg <= cp_addr_next;
    end

    assign col_ext    = 32'(cur_col_reg);
    assign row_ext    = 32'(cur_row_reg);
    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign cell_data  = rd_ok_reg ? rdata : '0;
    assign cursor_col = col_ext[COLIN_W-1:0];
    assign cursor_row = row_ext[ROWIN_W-1:0];

endmodule

// ----- hw/rtl/text_console_writer.sv -----
// text console writer top level with attribute register and checks
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------
//  command  | start, busy           | cmd, char_code, col, row
//  result   | done (one cycle)      | cell_data, cursor_col, cursor_row
//  config   | cfg_valid, cfg_ready  | cfg_data (text attribute)
//
//  put char, plain new line, set cursor, read cell: result in the cycle
//  after the accepting edge, and a new command is taken in that cycle
//  clear: one cell written per cycle by the sweep counter
//  new line on the last row: through the copy loop, then the drain state
//  after reset the store is cleared by the sweep counter with busy high
//  results cannot be held off; config writes are taken in every cycle
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tcw_pkg::CMD_W-1:0]   cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
    input  logic [tcw_pkg::COLIN_W-1:0] col,
    input  logic [tcw_pkg::ROWIN_W-1:0] row,
    output logic                        done,
    output logic [tcw_pkg::CELL_W-1:0]  cell_data,
    output logic [tcw_pkg::COLIN_W-1:0] cursor_col,
    output logic [tcw_pkg::ROWIN_W-1:0] cursor_row,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    assign cfg_ready = 1'b1;
    assign attr_next = (cfg_valid && cfg_ready) ? cfg_data : attr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= DEF_ATTR;
        end
        else
        begin
            attr_reg <= attr_next;
        end
    end

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .char_code  (char_code),
        .col        (col),
        .row        (row),
        .attr       (attr_reg),
        .rdata      (mem_rdata),
        .busy       (busy),
        .done       (done),
        .cell_data  (cell_data),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr)
    );

    tcw_screen_mem #(
        .CELLS  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while sequencer busy");

    a_put_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_PUT) |=> done)
        else $error("put char did not finish in one cycle");

    a_setcur: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_SETCUR && 32'(col) < COLUMNS && 32'(row) < ROWS)
        |=> (cursor_col == $past(col) && cursor_row == $past(row)))
        else $error("set cursor not reflected");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd != CMD_READ) |=> (cell_data == '0))
        else $error("cell data nonzero for non-read command");
`endif

endmodule
